/* design/buddy_block_allocator_defines.svh */
// assertion macros for the buddy block allocator
// expects aclk and aresetn in the scope of the module that uses them
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/bba_pkg.sv */
// shared constants, codes and helpers for the buddy block allocator
// no dependencies
`default_nettype none

package bba_pkg;

    localparam int DEF_MAX_ORDER   = 10;
    localparam int DEF_HANDLE_BITS = 32;
    localparam int SIZE_W          = 16;
    localparam int SIZE_ORD_W      = 5;
    localparam int OUT_NARROW_W    = 11;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FAIL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_HSCAN,
        S_SPLIT_RD,
        S_SPLIT_GET,
        S_RM_RD,
        S_RM_WR,
        S_PUSH_LO,
        S_PUSH_HI,
        S_TAKE,
        S_FCHK,
        S_QSCAN,
        S_MERGE,
        S_FPUSH,
        S_DONE
    } state_t;

    // smallest order whose block holds the size
    function automatic logic [SIZE_ORD_W-1:0] size_order(input logic [SIZE_W-1:0] size);
        logic [SIZE_ORD_W-1:0] r;
        int o;
        r = SIZE_ORD_W'(SIZE_W);
        for (o = SIZE_W; o >= 0; o--) begin
            if (((SIZE_W+1)'(1) << o) >= {1'b0, size}) begin
                r = SIZE_ORD_W'(o);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/buddy_block_allocator.sv */
// buddy allocator, one request in flight, the next one is taken once its result is registered
// allocate: scans the handle table for a free slot, pops the front of the found order's queue
// and shifts the entries behind it forward; each split level pushes both halves and pops again.
// free: scans the handle table for the matching handle, then compares queue entries for the buddy;
// each merge level removes the buddy from its queue. up-front failures go straight to the result.
// reset or a max_order write runs a handle table clearing pass over all 2^MAX_ORDER entries.
// depends on bba_pkg, bba_ram and buddy_block_allocator_defines.svh
`default_nettype none
`include "buddy_block_allocator_defines.svh"

module buddy_block_allocator #(
    parameter int MAX_ORDER   = bba_pkg::DEF_MAX_ORDER,
    parameter int HANDLE_BITS = bba_pkg::DEF_HANDLE_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [3:0]   cfg_data,       // max_order
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,   // request_size[15:0], handle_in[47:16]
    input  wire logic [0:0]   s_axis_tuser,   // opcode
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [175:0]      m_axis_tdata,   // handle_out, used_bytes, requested_bytes,
                                              // alloc_requests, alloc_successes,
                                              // alloc_failures, free blocks,
                                              // largest free block, zero pad
    output logic [1:0]        m_axis_tuser    // status
);

    localparam int M   = MAX_ORDER;
    localparam int HB  = HANDLE_BITS;
    localparam int OW  = $clog2(M + 1);
    localparam int AW  = M;
    localparam int QAW = M + 1;
    localparam int QLW = M + 1;
    localparam int CW  = M + 1;
    localparam int HD  = 1 << M;
    localparam int QD  = 2 << M;
    localparam int NW  = bba_pkg::OUT_NARROW_W;

    typedef struct packed {
        logic                      valid;
        logic [HB-1:0]             handle;
        logic [AW-1:0]             addr;
        logic [OW-1:0]             order;
        logic [bba_pkg::SIZE_W-1:0] req;
    } entry_t;

    localparam int EW = $bits(entry_t);

    function automatic logic [QAW-1:0] qbase(input logic [OW-1:0] o);
        logic [QAW:0] t;
        t = ((QAW+1)'(1) << (M + 1)) - ((QAW+1)'(2) << (M - int'(o)));
        return t[QAW-1:0];
    endfunction

    function automatic logic [QLW-1:0] qcap(input logic [OW-1:0] o);
        return QLW'(1) << (M - int'(o));
    endfunction

    // ram ports
    logic           q_we;
    logic [QAW-1:0] q_waddr, q_raddr;
    logic [AW-1:0]  q_wdata, q_rdata;
    logic           h_we;
    logic [M-1:0]   h_waddr, h_raddr;
    entry_t         h_wdata, h_rdata;

    bba_ram #(.WIDTH(AW), .DEPTH(QD)) u_queue_ram (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    bba_ram #(.WIDTH(EW), .DEPTH(HD)) u_handle_ram (
        .aclk(aclk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    // control state
    bba_pkg::state_t state_reg, state_next;
    logic [OW-1:0]  mo_reg, mo_next;
    logic [QLW-1:0] qlen_reg [0:M];
    logic [QLW-1:0] qlen_next [0:M];
    logic [HB-1:0]  nh_reg, nh_next;
    logic [CW-1:0]  used_reg, used_next;
    logic [CW-1:0]  reqb_reg, reqb_next;
    logic [31:0]    areq_reg, areq_next;
    logic [31:0]    asucc_reg, asucc_next;
    logic [31:0]    afail_reg, afail_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           m_valid_reg, m_valid_next;
    logic [M:0]     clr_reg, clr_next;
    logic [M:0]     sc_reg, sc_next;
    logic           chk_reg, chk_next;
    logic           op_reg, op_next;

    // payload state
    logic [M-1:0]   chkaddr_reg, chkaddr_next;
    logic [M-1:0]   slot_reg, slot_next;
    logic [OW-1:0]  ord_reg, ord_next;
    logic [OW-1:0]  need_reg, need_next;
    logic [AW-1:0]  a_reg, a_next;
    logic [AW-1:0]  buddy_reg, buddy_next;
    logic [QLW-1:0] rmk_reg, rmk_next;
    logic [QLW-1:0] qs_reg, qs_next;
    logic [QLW-1:0] qci_reg, qci_next;
    logic [bba_pkg::SIZE_W-1:0] req_reg, req_next;
    logic [31:0]    h_reg, h_next;
    logic [1:0]     st_reg, st_next;
    logic [HB-1:0]  ho_reg, ho_next;
    logic [175:0]   m_data_reg, m_data_next;
    logic [1:0]     m_user_reg, m_user_next;

    // request decode
    logic                          in_op;
    logic [bba_pkg::SIZE_W-1:0]    in_size;
    logic [31:0]                   in_handle;
    logic [bba_pkg::SIZE_ORD_W-1:0] in_ord;
    logic                          cur_found;
    logic [OW-1:0]                 cur_o;
    logic [31:0]                   largest;
    logic [QLW-1:0]                qn;
    logic                          hhit;
    logic [AW-1:0]                 pdata;

    assign in_op     = s_axis_tuser[0];
    assign in_size   = s_axis_tdata[15:0];
    assign in_handle = s_axis_tdata[47:16];
    assign in_ord    = bba_pkg::size_order(in_size);
    assign qn        = qlen_reg[ord_reg];

    always_comb begin
        cur_found = 1'b0;
        cur_o     = '0;
        for (int o = M; o >= 0; o--) begin
            if (o >= int'(in_ord) && o <= int'(mo_reg) && qlen_reg[o] != '0) begin
                cur_found = 1'b1;
                cur_o     = OW'(o);
            end
        end
        largest = '0;
        for (int o = 0; o <= M; o++) begin
            if (qlen_reg[o] != '0) begin
                largest = 32'(1) << o;
            end
        end
    end

    assign hhit = chk_reg && ((op_reg == bba_pkg::OP_ALLOC) ? !h_rdata.valid
                  : (h_rdata.valid && 32'(h_rdata.handle) == h_reg));

    always_comb begin
        state_next   = state_reg;
        mo_next      = mo_reg;
        for (int o = 0; o <= M; o++) qlen_next[o] = qlen_reg[o];
        nh_next      = nh_reg;
        used_next    = used_reg;
        reqb_next    = reqb_reg;
        areq_next    = areq_reg;
        asucc_next   = asucc_reg;
        afail_next   = afail_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        clr_next     = clr_reg;
        sc_next      = sc_reg;
        chk_next     = chk_reg;
        op_next      = op_reg;
        chkaddr_next = chkaddr_reg;
        slot_next    = slot_reg;
        ord_next     = ord_reg;
        need_next    = need_reg;
        a_next       = a_reg;
        buddy_next   = buddy_reg;
        rmk_next     = rmk_reg;
        qs_next      = qs_reg;
        qci_next     = qci_reg;
        req_next     = req_reg;
        h_next       = h_reg;
        st_next      = st_reg;
        ho_next      = ho_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        q_we    = 1'b0;
        q_waddr = qbase(ord_reg) + qn;
        q_wdata = a_reg;
        q_raddr = qbase(ord_reg);
        h_we    = 1'b0;
        h_waddr = clr_reg[M-1:0];
        h_wdata = '0;
        h_raddr = sc_reg[M-1:0];
        pdata   = a_reg;

        unique case (state_reg)
            bba_pkg::S_INIT: begin
                h_we = 1'b1;
                if (clr_reg == '0) begin
                    // the single top block at address zero
                    q_we    = 1'b1;
                    q_waddr = qbase(mo_reg);
                    q_wdata = '0;
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (M+1)'(HD - 1)) begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE: begin
                if (cfg_valid) begin
                    mo_next = (int'(cfg_data) > M) ? OW'(M) : OW'(cfg_data);
                    for (int o = 0; o <= M; o++) qlen_next[o] = '0;
                    qlen_next[mo_next] = QLW'(1);
                    nh_next    = HB'(1);
                    used_next  = '0;
                    reqb_next  = '0;
                    areq_next  = '0;
                    asucc_next = '0;
                    afail_next = '0;
                    cnt_next   = CW'(1);
                    clr_next   = '0;
                    state_next = bba_pkg::S_INIT;
                end else if (s_axis_tvalid) begin
                    op_next  = in_op;
                    h_next   = in_handle;
                    req_next = in_size;
                    ho_next  = '0;
                    sc_next  = '0;
                    chk_next = 1'b0;
                    if (in_op == bba_pkg::OP_ALLOC) begin
                        areq_next = areq_reg + 1'b1;
                        if (in_size == '0 || int'(in_ord) > int'(mo_reg) || !cur_found) begin
                            afail_next = afail_reg + 1'b1;
                            st_next    = bba_pkg::ST_FAIL;
                            state_next = bba_pkg::S_DONE;
                        end else begin
                            need_next  = OW'(in_ord);
                            ord_next   = cur_o;
                            state_next = bba_pkg::S_HSCAN;
                        end
                    end else begin
                        state_next = bba_pkg::S_HSCAN;
                    end
                end
            end
            bba_pkg::S_HSCAN: begin
                if (hhit) begin
                    slot_next = chkaddr_reg;
                    if (op_reg == bba_pkg::OP_ALLOC) begin
                        state_next = bba_pkg::S_SPLIT_RD;
                    end else begin
                        h_we       = 1'b1;
                        h_waddr    = chkaddr_reg;
                        a_next     = h_rdata.addr;
                        ord_next   = h_rdata.order;
                        used_next  = used_reg - (CW'(1) << h_rdata.order);
                        reqb_next  = reqb_reg - CW'(h_rdata.req);
                        state_next = bba_pkg::S_FCHK;
                    end
                end else if (chk_reg && chkaddr_reg == M'(HD - 1)) begin
                    if (op_reg == bba_pkg::OP_ALLOC) begin
                        afail_next = afail_reg + 1'b1;
                        st_next    = bba_pkg::ST_FAIL;
                    end else begin
                        st_next = bba_pkg::ST_UNKNOWN;
                    end
                    state_next = bba_pkg::S_DONE;
                end else begin
                    // read one entry a cycle, compare it the cycle after
                    chk_next     = 1'b1;
                    chkaddr_next = sc_reg[M-1:0];
                    sc_next      = sc_reg + 1'b1;
                end
            end
            bba_pkg::S_SPLIT_RD: begin
                state_next = bba_pkg::S_SPLIT_GET;
            end
            bba_pkg::S_SPLIT_GET: begin
                a_next     = q_rdata;
                rmk_next   = '0;
                state_next = bba_pkg::S_RM_RD;
            end
            bba_pkg::S_RM_RD: begin
                if (rmk_reg + 1'b1 < qn) begin
                    q_raddr    = qbase(ord_reg) + rmk_reg + 1'b1;
                    state_next = bba_pkg::S_RM_WR;
                end else begin
                    qlen_next[ord_reg] = qn - 1'b1;
                    cnt_next           = cnt_reg - 1'b1;
                    if (op_reg == bba_pkg::OP_FREE) begin
                        state_next = bba_pkg::S_MERGE;
                    end else if (ord_reg != need_reg) begin
                        ord_next   = ord_reg - 1'b1;
                        state_next = bba_pkg::S_PUSH_LO;
                    end else begin
                        state_next = bba_pkg::S_TAKE;
                    end
                end
            end
            bba_pkg::S_RM_WR: begin
                q_we       = 1'b1;
                q_waddr    = qbase(ord_reg) + rmk_reg;
                q_wdata    = q_rdata;
                rmk_next   = rmk_reg + 1'b1;
                state_next = bba_pkg::S_RM_RD;
            end
            bba_pkg::S_PUSH_LO, bba_pkg::S_PUSH_HI, bba_pkg::S_FPUSH: begin
                if (state_reg == bba_pkg::S_PUSH_HI) begin
                    pdata = a_reg + (AW'(1) << ord_reg);
                end
                if (qn < qcap(ord_reg)) begin
                    q_we               = 1'b1;
                    q_wdata            = pdata;
                    qlen_next[ord_reg] = qn + 1'b1;
                    cnt_next           = cnt_reg + 1'b1;
                end
                if (state_reg == bba_pkg::S_PUSH_LO) begin
                    state_next = bba_pkg::S_PUSH_HI;
                end else if (state_reg == bba_pkg::S_PUSH_HI) begin
                    state_next = bba_pkg::S_SPLIT_RD;
                end else begin
                    st_next    = bba_pkg::ST_OK;
                    state_next = bba_pkg::S_DONE;
                end
            end
            bba_pkg::S_TAKE: begin
                h_we           = 1'b1;
                h_waddr        = slot_reg;
                h_wdata.valid  = 1'b1;
                h_wdata.handle = nh_reg;
                h_wdata.addr   = a_reg;
                h_wdata.order  = need_reg;
                h_wdata.req    = req_reg;
                ho_next        = nh_reg;
                nh_next        = nh_reg + 1'b1;
                used_next      = used_reg + (CW'(1) << need_reg);
                reqb_next      = reqb_reg + CW'(req_reg);
                asucc_next     = asucc_reg + 1'b1;
                st_next        = bba_pkg::ST_OK;
                state_next     = bba_pkg::S_DONE;
            end
            bba_pkg::S_FCHK: begin
                if (ord_reg < mo_reg) begin
                    buddy_next = a_reg ^ (AW'(1) << ord_reg);
                    qs_next    = '0;
                    chk_next   = 1'b0;
                    state_next = bba_pkg::S_QSCAN;
                end else begin
                    state_next = bba_pkg::S_FPUSH;
                end
            end
            bba_pkg::S_QSCAN: begin
                q_raddr = qbase(ord_reg) + qs_reg;
                if (chk_reg && q_rdata == buddy_reg) begin
                    rmk_next   = qci_reg;
                    state_next = bba_pkg::S_RM_RD;
                end else if (qn == '0 || (chk_reg && qci_reg == qn - 1'b1)) begin
                    state_next = bba_pkg::S_FPUSH;
                end else begin
                    chk_next = 1'b1;
                    qci_next = qs_reg;
                    qs_next  = qs_reg + 1'b1;
                end
            end
            bba_pkg::S_MERGE: begin
                if (buddy_reg < a_reg) begin
                    a_next = buddy_reg;
                end
                ord_next   = ord_reg + 1'b1;
                state_next = bba_pkg::S_FCHK;
            end
            bba_pkg::S_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = st_reg;
                    m_data_next  = {4'b0,
                                    NW'(largest),
                                    NW'(32'(cnt_reg)),
                                    afail_reg,
                                    asucc_reg,
                                    areq_reg,
                                    NW'(32'(reqb_reg)),
                                    NW'(32'(used_reg)),
                                    32'(ho_reg)};
                    state_next   = bba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bba_pkg::S_INIT;
            mo_reg    <= OW'(M);
            for (int o = 0; o <= M; o++) begin
                qlen_reg[o] <= (o == M) ? QLW'(1) : '0;
            end
            nh_reg      <= HB'(1);
            used_reg    <= '0;
            reqb_reg    <= '0;
            areq_reg    <= '0;
            asucc_reg   <= '0;
            afail_reg   <= '0;
            cnt_reg     <= CW'(1);
            m_valid_reg <= 1'b0;
            clr_reg     <= '0;
            sc_reg      <= '0;
            chk_reg     <= 1'b0;
            op_reg      <= bba_pkg::OP_ALLOC;
        end else begin
            state_reg <= state_next;
            mo_reg    <= mo_next;
            for (int o = 0; o <= M; o++) begin
                qlen_reg[o] <= qlen_next[o];
            end
            nh_reg      <= nh_next;
            used_reg    <= used_next;
            reqb_reg    <= reqb_next;
            areq_reg    <= areq_next;
            asucc_reg   <= asucc_next;
            afail_reg   <= afail_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            clr_reg     <= clr_next;
            sc_reg      <= sc_next;
            chk_reg     <= chk_next;
            op_reg      <= op_next;
        end
    end

    always_ff @(posedge aclk) begin
        chkaddr_reg <= chkaddr_next;
        slot_reg    <= slot_next;
        ord_reg     <= ord_next;
        need_reg    <= need_next;
        a_reg       <= a_next;
        buddy_reg   <= buddy_next;
        rmk_reg     <= rmk_next;
        qs_reg      <= qs_next;
        qci_reg     <= qci_next;
        req_reg     <= req_next;
        h_reg       <= h_next;
        st_reg      <= st_next;
        ho_reg      <= ho_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

    assign cfg_ready     = (state_reg == bba_pkg::S_IDLE);
    assign s_axis_tready = (state_reg == bba_pkg::S_IDLE) && !cfg_valid;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    `BBA_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg <= CW'(HD), "free count too big")
    `BBA_ASSERT_NOW(a_used_range, 1'b1, used_reg <= (CW'(1) << mo_reg), "used too big")
    `BBA_ASSERT_NEXT(a_cfg_init, cfg_valid && cfg_ready, state_reg == bba_pkg::S_INIT, "no init")
    `BBA_ASSERT_NOW(a_result_src, $rose(m_valid_reg), $past(state_reg) == bba_pkg::S_DONE, "stray")

endmodule

`default_nettype wire

/* design/bba_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
